// File: rtl/bsc_pkg.sv
// Package for the barometric sensor compensation block.
// Holds the calibration field helpers and the fixed constants; no dependencies.
package bsc_pkg;

    localparam int unsigned CAL_W   = 48;
    localparam int unsigned RAW_W   = 20;
    localparam int unsigned IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_CALIB_TEMP    = 2'd0;
    localparam logic [IDX_W-1:0] REG_CALIB_PRESS_A = 2'd1;
    localparam logic [IDX_W-1:0] REG_CALIB_PRESS_B = 2'd2;
    localparam logic [IDX_W-1:0] REG_CALIB_PRESS_C = 2'd3;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] RAW_BASE    = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [63:0] P1_BIAS     = 64'd1 << 47;
    localparam logic [63:0] TEMP_SCALE  = 64'd5;
    localparam logic [31:0] TEMP_ROUND  = 32'd128;

    // Signed 16-bit calibration word, sign extended to 64 bits.
    function automatic logic [63:0] word_s(input logic [CAL_W-1:0] r, input int unsigned k);
        logic [15:0] w;
        w = r[16*k +: 16];
        return {{48{w[15]}}, w};
    endfunction

    // Unsigned 16-bit calibration word, zero extended to 64 bits.
    function automatic logic [63:0] word_u(input logic [CAL_W-1:0] r, input int unsigned k);
        return {48'd0, r[16*k +: 16]};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

endpackage

// File: rtl/bsc_if.sv
// Valid/ready channels of the barometric sensor compensation block.
// Depends on bsc_pkg for the raw sample width.
interface bsc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [bsc_pkg::RAW_W-1:0]      raw_sample;
    modport source (output valid, action, raw_sample, input ready);
    modport sink   (input valid, action, raw_sample, output ready);
endinterface

interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               divide_fault;
    modport source (output valid, kind, temperature_centi, pressure_q24_8, divide_fault,
                    input ready);
    modport sink   (input valid, kind, temperature_centi, pressure_q24_8, divide_fault,
                    output ready);
endinterface

// File: rtl/barometric_sensor_compensation.sv
// Barometric sensor compensation: one item in, one compensated reading out. Every product goes
// through one shared 32x32 multiplier that builds a 64-bit wrapped product, and a pressure item
// also runs a restoring divider that retires one quotient bit per cycle. Every item, whether a
// temperature item, a pressure item or a pressure item whose divisor is zero, reaches the output
// register on the edge that makes the input ready again, so the next item can be accepted in the
// cycle after that edge. The block takes one item at a time; a finished result waits in the
// output register, so the next item is accepted while it waits, and only a result that finds
// that register still full stalls the block. Depends on bsc_pkg and the channel interfaces.
module barometric_sensor_compensation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsc_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [bsc_pkg::CAL_W-1:0]      i_cfg_data,
    bsc_in_if.sink                         in_ch,
    bsc_out_if.source                      out_ch
);

    typedef enum logic [4:0] {
        S_IDLE, T_A, T_B, T_C, T_D,
        P_V1, P_SQ, P_M6, P_M5, P_M3, P_M2, P_M1, P_NUM, P_DIV, P_SGN,
        P_S9, P_SS, P_M8, P_FIN, S_DONE
    } t_state;

    t_state                   r_state;
    logic [bsc_pkg::CAL_W-1:0] r_ct, r_pa, r_pb, r_pc;
    logic                     r_act;
    logic [bsc_pkg::RAW_W-1:0] r_raw;
    logic [31:0]              r_fine;
    logic [63:0]              r_a, r_b, r_c, r_sq, r_p;
    logic                     r_qneg;
    logic [1:0]               r_mph;
    logic [5:0]               r_cnt;
    logic [63:0]              r_pp, r_acc;
    logic signed [15:0]       r_tc;
    logic [31:0]              r_pr;
    logic                     r_flt;
    logic                     r_ov;

    logic               r_act_o;
    logic signed [15:0] r_tc_o;
    logic [31:0]        r_pr_o;
    logic               r_flt_o;

    logic [63:0] mul_a, mul_b, mres, s13, pterm, num_base, p1v;
    logic [31:0] mul_x, mul_y;
    logic [31:0] ta, tb, tv2, tt;
    logic [64:0] trial;
    logic        is_mul, mul_done;

    assign is_mul   = r_state inside {T_A, T_B, T_C, T_D, P_SQ, P_M6, P_M5, P_M3, P_M2,
                                      P_M1, P_NUM, P_S9, P_SS, P_M8};
    assign mul_done = (r_mph == 2'd3);
    assign mres     = r_acc + {r_pp[31:0], 32'd0};

    assign ta       = 32'(r_raw[19:3]) - (32'(r_ct[15:0]) << 1);
    assign tb       = 32'(r_raw[19:4]) - 32'(r_ct[15:0]);
    assign s13      = 64'($signed(r_p) >>> 13);
    assign num_base = ((bsc_pkg::RAW_BASE - 64'(r_raw)) << 31) - r_b;
    assign p1v      = bsc_pkg::P1_BIAS + r_c;
    assign tv2      = 32'($signed(mres[31:0]) >>> 14);
    assign tt       = 32'($signed(mres[31:0] + bsc_pkg::TEMP_ROUND) >>> 8);
    assign pterm    = 64'($signed(r_p + r_a + r_b) >>> 8)
                    + (bsc_pkg::word_s(r_pc, 0) << 4);
    assign trial    = {r_sq, r_p[63]} - {1'b0, r_b};

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            T_A:  begin mul_a = bsc_pkg::sx32(ta);        mul_b = bsc_pkg::word_s(r_ct, 1); end
            T_B:  begin mul_a = bsc_pkg::sx32(tb);        mul_b = bsc_pkg::sx32(tb); end
            T_C:  begin mul_a = bsc_pkg::sx32(r_sq[31:0]); mul_b = bsc_pkg::word_s(r_ct, 2); end
            T_D:  begin mul_a = bsc_pkg::sx32(r_fine);    mul_b = bsc_pkg::TEMP_SCALE; end
            P_SQ: begin mul_a = r_a;  mul_b = r_a; end
            P_M6: begin mul_a = r_sq; mul_b = bsc_pkg::word_s(r_pb, 2); end
            P_M5: begin mul_a = r_a;  mul_b = bsc_pkg::word_s(r_pb, 1); end
            P_M3: begin mul_a = r_sq; mul_b = bsc_pkg::word_s(r_pa, 2); end
            P_M2: begin mul_a = r_a;  mul_b = bsc_pkg::word_s(r_pa, 1); end
            P_M1: begin mul_a = p1v;  mul_b = bsc_pkg::word_u(r_pa, 0); end
            P_NUM: begin mul_a = num_base; mul_b = bsc_pkg::PRESS_SCALE; end
            P_S9: begin mul_a = bsc_pkg::word_s(r_pc, 2); mul_b = s13; end
            P_SS: begin mul_a = r_a;  mul_b = s13; end
            P_M8: begin mul_a = bsc_pkg::word_s(r_pc, 1); mul_b = r_p; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        // Low-by-low, low-by-high, then high-by-low: enough for a product modulo 2^64.
        case (r_mph)
            2'd0:    begin mul_x = mul_a[31:0];  mul_y = mul_b[31:0]; end
            2'd1:    begin mul_x = mul_a[31:0];  mul_y = mul_b[63:32]; end
            default: begin mul_x = mul_a[63:32]; mul_y = mul_b[31:0]; end
        endcase
    end

    assign in_ch.ready              = (r_state == S_IDLE);
    assign out_ch.valid             = r_ov;
    assign out_ch.kind              = r_act_o;
    assign out_ch.temperature_centi = r_tc_o;
    assign out_ch.pressure_q24_8    = r_pr_o;
    assign out_ch.divide_fault      = r_flt_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ct    <= '0;
            r_pa    <= '0;
            r_pb    <= '0;
            r_pc    <= '0;
            r_fine  <= '0;
            r_mph   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bsc_pkg::REG_CALIB_TEMP:    r_ct <= i_cfg_data;
                    bsc_pkg::REG_CALIB_PRESS_A: r_pa <= i_cfg_data;
                    bsc_pkg::REG_CALIB_PRESS_B: r_pb <= i_cfg_data;
                    bsc_pkg::REG_CALIB_PRESS_C: r_pc <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_DONE && (!r_ov || out_ch.ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && out_ch.ready) begin
                r_ov <= 1'b0;
            end

            if (is_mul) begin
                r_pp  <= 64'(mul_x) * 64'(mul_y);
                r_mph <= r_mph + 2'd1;
                if (r_mph == 2'd1) begin
                    r_acc <= r_pp;
                end else if (r_mph == 2'd2) begin
                    r_acc <= mres;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_act   <= in_ch.action;
                        r_raw   <= in_ch.raw_sample;
                        r_state <= in_ch.action ? P_V1 : T_A;
                    end
                end
                T_A: if (mul_done) begin
                    r_a[31:0] <= 32'($signed(mres[31:0]) >>> 11);
                    r_state   <= T_B;
                end
                T_B: if (mul_done) begin
                    r_sq[31:0] <= 32'($signed(mres[31:0]) >>> 12);
                    r_state    <= T_C;
                end
                T_C: if (mul_done) begin
                    r_fine  <= r_a[31:0] + tv2;
                    r_state <= T_D;
                end
                T_D: if (mul_done) begin
                    if ($signed(tt) > 32'sd32767) begin
                        r_tc <= 16'sh7FFF;
                    end else if ($signed(tt) < -32'sd32768) begin
                        r_tc <= 16'sh8000;
                    end else begin
                        r_tc <= tt[15:0];
                    end
                    r_pr    <= '0;
                    r_flt   <= 1'b0;
                    r_state <= S_DONE;
                end
                P_V1: begin
                    r_a     <= bsc_pkg::sx32(r_fine) - bsc_pkg::FINE_OFFSET;
                    r_state <= P_SQ;
                end
                P_SQ: if (mul_done) begin
                    r_sq    <= mres;
                    r_state <= P_M6;
                end
                P_M6: if (mul_done) begin
                    r_b     <= mres;
                    r_state <= P_M5;
                end
                P_M5: if (mul_done) begin
                    r_b     <= r_b + (mres << 17) + (bsc_pkg::word_s(r_pb, 0) << 35);
                    r_state <= P_M3;
                end
                P_M3: if (mul_done) begin
                    r_c     <= 64'($signed(mres) >>> 8);
                    r_state <= P_M2;
                end
                P_M2: if (mul_done) begin
                    r_c     <= r_c + (mres << 12);
                    r_state <= P_M1;
                end
                P_M1: if (mul_done) begin
                    r_c <= 64'($signed(mres) >>> 33);
                    if (64'($signed(mres) >>> 33) == 64'd0) begin
                        r_tc    <= '0;
                        r_pr    <= '0;
                        r_flt   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= P_NUM;
                    end
                end
                P_NUM: if (mul_done) begin
                    // Divide magnitudes; the sign is put back afterwards.
                    r_p     <= mres[63] ? (64'd0 - mres) : mres;
                    r_b     <= r_c[63] ? (64'd0 - r_c) : r_c;
                    r_qneg  <= mres[63] ^ r_c[63];
                    r_sq    <= '0;
                    r_cnt   <= '0;
                    r_state <= P_DIV;
                end
                P_DIV: begin
                    r_sq  <= trial[64] ? {r_sq[62:0], r_p[63]} : trial[63:0];
                    r_p   <= {r_p[62:0], ~trial[64]};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= P_SGN;
                    end
                end
                P_SGN: begin
                    r_p     <= r_qneg ? (64'd0 - r_p) : r_p;
                    r_state <= P_S9;
                end
                P_S9: if (mul_done) begin
                    r_a     <= mres;
                    r_state <= P_SS;
                end
                P_SS: if (mul_done) begin
                    r_a     <= 64'($signed(mres) >>> 25);
                    r_state <= P_M8;
                end
                P_M8: if (mul_done) begin
                    r_b     <= 64'($signed(mres) >>> 19);
                    r_state <= P_FIN;
                end
                P_FIN: begin
                    r_tc    <= '0;
                    r_pr    <= pterm[31:0];
                    r_flt   <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || out_ch.ready) begin
                        r_act_o <= r_act;
                        r_tc_o  <= r_tc;
                        r_pr_o  <= r_pr;
                        r_flt_o <= r_flt;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_flt_o) |-> (r_pr_o == 32'd0 && r_act_o))
        else $error("fault reported with a nonzero pressure");

    a_temp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_act_o) |-> (r_pr_o == 32'd0 && !r_flt_o))
        else $error("temperature item carries pressure fields");

    a_mul_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mph != 2'd0) |-> is_mul)
        else $error("multiplier phase advanced outside a multiply step");

endmodule

// File: tb/tb.sv
// Self-checking testbench for barometric_sensor_compensation.
// Drives temperature and pressure items through the valid/ready channels and checks each
// reading against an in-bench fixed-point compensation model. Depends on bsc_pkg, bsc_if.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit ACT_TEMP  = 1'b0;
    localparam bit ACT_PRESS = 1'b1;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic        kind;
        logic [15:0] temp;
        logic [31:0] press;
        logic        fault;
    } t_reading;

    typedef struct {
        logic        act;
        logic [19:0] raw;
        bit          known;
        t_reading    want;
    } t_stim;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [bsc_pkg::IDX_W-1:0] i_cfg_idx;
    logic [bsc_pkg::CAL_W-1:0] i_cfg_data;

    bsc_in_if  in_ch ();
    bsc_out_if out_ch ();

    barometric_sensor_compensation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source)
    );

    // Predictor state.
    logic [47:0] cal_t, cal_pa, cal_pb, cal_pc;
    logic [31:0] fine_t;
    t_reading    readings_due[$];
    int          mismatches;
    int          cycles;
    bit          calm;   // no random idling while set

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("barometric_sensor_compensation regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] ws(input logic [47:0] r, input int k);
        logic [15:0] w;
        w = r[16*k +: 16];
        return {{48{w[15]}}, w};
    endfunction

    function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] mn, md, q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q = mn / md;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic t_reading compensate(input logic act, input logic [19:0] raw);
        t_reading r;
        logic [31:0] t1, t2, t3, a, b, bb, v1, v2, t;
        logic signed [31:0] ts;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, ft, w1, w2, p, s, q;
        r = '0;
        r.kind = act;
        if (act == ACT_TEMP) begin
            t1 = {16'd0, cal_t[15:0]};
            t2 = 32'(ws(cal_t, 1));
            t3 = 32'(ws(cal_t, 2));
            a = {12'd0, raw} / 8 - (t1 << 1);
            b = {12'd0, raw} / 16 - t1;
            v1 = $signed(a * t2) >>> 11;
            bb = $signed(b * b) >>> 12;
            v2 = $signed(bb * t3) >>> 14;
            fine_t = v1 + v2;
            t = $signed(fine_t * 32'd5 + 32'd128) >>> 8;
            ts = $signed(t);
            if (ts > 32767) r.temp = 16'h7fff;
            else if (ts < -32768) r.temp = 16'h8000;
            else r.temp = ts[15:0];
        end else begin
            p1 = {48'd0, cal_pa[15:0]};
            p2 = ws(cal_pa, 1); p3 = ws(cal_pa, 2);
            p4 = ws(cal_pb, 0); p5 = ws(cal_pb, 1); p6 = ws(cal_pb, 2);
            p7 = ws(cal_pc, 0); p8 = ws(cal_pc, 1); p9 = ws(cal_pc, 2);
            ft = {{32{fine_t[31]}}, fine_t};
            w1 = ft - 64'd128000;
            w2 = w1 * w1 * p6;
            w2 = w2 + ((w1 * p5) << 17);
            w2 = w2 + (p4 << 35);
            q = $signed(w1 * w1 * p3) >>> 8;
            w1 = q + ((w1 * p2) << 12);
            w1 = $signed(((64'd1 << 47) + w1) * p1) >>> 33;
            if (w1 == 64'd0) begin
                r.fault = 1'b1;
            end else begin
                p = 64'd1048576 - {44'd0, raw};
                p = div_trunc(((p << 31) - w2) * 64'd3125, w1);
                s = $signed(p) >>> 13;
                w1 = $signed(p9 * s * s) >>> 25;
                w2 = $signed(p8 * p) >>> 19;
                q = $signed(p + w1 + w2) >>> 8;
                p = q + (p7 << 4);
                r.press = p[31:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_reading got, input t_reading want);
        mismatches++;
        $display("mismatch %s: got k=%0d t=%0d p=%h f=%0d want k=%0d t=%0d p=%h f=%0d", what,
                 got.kind, $signed(got.temp), got.press, got.fault,
                 want.kind, $signed(want.temp), want.press, want.fault);
    endtask

    // Output side: random stalls and checking.
    always @(posedge i_clk) begin
        t_reading got, want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.kind, out_ch.temperature_centi, out_ch.pressure_q24_8,
                        out_ch.divide_fault};
                if (readings_due.size() == 0) begin
                    report_mismatch("unexpected", got, got);
                end else begin
                    want = readings_due.pop_front();
                    if (got !== want) report_mismatch("field", got, want);
                end
            end
            out_ch.ready <= calm || ($urandom_range(99) >= 35);
        end
    end

    // The write enable drops in the cycle after the write, so back-to-back calls never
    // schedule two updates of it in the same step.
    task automatic cfg_write(input logic [bsc_pkg::IDX_W-1:0] idx, input logic [47:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bsc_pkg::REG_CALIB_TEMP:    cal_t  = val;
            bsc_pkg::REG_CALIB_PRESS_A: cal_pa = val;
            bsc_pkg::REG_CALIB_PRESS_B: cal_pb = val;
            default:                    cal_pc = val;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Send one item; the expected reading is queued when it is accepted. Valid stays high
    // afterwards until the next send idles or a drain drops it.
    task automatic send(input logic act, input logic [19:0] raw, input bit known,
                        input t_reading want);
        t_reading r;
        while (!calm && $urandom_range(99) < 35) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.raw_sample <= raw;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        r = compensate(act, raw);
        if (known && r !== want) report_mismatch("directed", r, want);
        readings_due.push_back(known ? want : r);
    endtask

    function automatic logic [47:0] rand_cal();
        return {16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535))};
    endfunction

    function automatic logic [47:0] typical_temp_cal();
        return {16'($urandom_range(60000, 65535)), 16'($urandom_range(20000, 30000)),
                16'($urandom_range(25000, 30000))};
    endfunction

    t_stim directed[$];
    t_reading none;

    initial begin
        cycles = 0;
        mismatches = 0;
        calm = 1'b0;
        none = '0;
        cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0;
        fine_t = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.raw_sample = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All calibration zero: temperature reads 0, pressure divisor is zero.
        directed.push_back('{ACT_TEMP, 20'd0, 1'b1, '{ACT_TEMP, 16'd0, 32'd0, 1'b0}});
        directed.push_back('{ACT_PRESS, 20'hfffff, 1'b1, '{ACT_PRESS, 16'd0, 32'd0, 1'b1}});
        directed.push_back('{ACT_PRESS, 20'd0, 1'b1, '{ACT_PRESS, 16'd0, 32'd0, 1'b1}});
        directed.push_back('{ACT_TEMP, 20'hfffff, 1'b1, '{ACT_TEMP, 16'd0, 32'd0, 1'b0}});
        foreach (directed[i])
            send(directed[i].act, directed[i].raw, directed[i].known, directed[i].want);
        drain();

        // Typical calibration, then extreme calibration words.
        cfg_write(bsc_pkg::REG_CALIB_TEMP, {16'hfc18, 16'h6770, 16'h6e7e});
        cfg_write(bsc_pkg::REG_CALIB_PRESS_A, {16'h2710, 16'hd6d0, 16'h8e78});
        cfg_write(bsc_pkg::REG_CALIB_PRESS_B, {16'hff9c, 16'h0064, 16'h2ba0});
        cfg_write(bsc_pkg::REG_CALIB_PRESS_C, {16'h1770, 16'hc6b8, 16'h000f});
        directed.delete();
        directed.push_back('{ACT_PRESS, 20'h65000, 1'b0, none});
        directed.push_back('{ACT_TEMP, 20'h7e000, 1'b0, none});
        directed.push_back('{ACT_PRESS, 20'h65000, 1'b0, none});
        directed.push_back('{ACT_PRESS, 20'h00000, 1'b0, none});
        directed.push_back('{ACT_PRESS, 20'hfffff, 1'b0, none});
        directed.push_back('{ACT_TEMP, 20'h00000, 1'b0, none});
        directed.push_back('{ACT_TEMP, 20'hfffff, 1'b0, none});
        directed.push_back('{ACT_PRESS, 20'h55555, 1'b0, none});
        foreach (directed[i])
            send(directed[i].act, directed[i].raw, 1'b0, none);
        drain();
        cfg_write(bsc_pkg::REG_CALIB_TEMP, 48'hffff_ffff_ffff);
        cfg_write(bsc_pkg::REG_CALIB_PRESS_A, 48'h7fff_8000_ffff);
        cfg_write(bsc_pkg::REG_CALIB_PRESS_B, 48'h7fff_7fff_7fff);
        cfg_write(bsc_pkg::REG_CALIB_PRESS_C, 48'h8000_8000_8000);
        send(ACT_TEMP, 20'hfffff, 1'b0, none);
        send(ACT_PRESS, 20'hfffff, 1'b0, none);
        send(ACT_TEMP, 20'h00000, 1'b0, none);
        send(ACT_PRESS, 20'h00001, 1'b0, none);
        send(ACT_TEMP, 20'h80000, 1'b0, none);
        send(ACT_PRESS, 20'h80000, 1'b0, none);
        drain();

        // Random phases: mostly realistic calibration, some fully random.
        for (int ph = 0; ph < 14; ph++) begin
            calm = (ph == 5);
            if (ph % 4 == 3) begin
                cfg_write(bsc_pkg::REG_CALIB_TEMP, rand_cal());
                cfg_write(bsc_pkg::REG_CALIB_PRESS_A, rand_cal());
            end else begin
                cfg_write(bsc_pkg::REG_CALIB_TEMP, typical_temp_cal());
                cfg_write(bsc_pkg::REG_CALIB_PRESS_A,
                          {32'(rand_cal() >> 16), 16'($urandom_range(1, 65535))});
            end
            cfg_write(bsc_pkg::REG_CALIB_PRESS_B, rand_cal());
            cfg_write(bsc_pkg::REG_CALIB_PRESS_C, rand_cal());
            for (int n = 0; n < 125; n++) begin
                if ($urandom_range(3) == 0)
                    send(1'($urandom_range(1)), 20'($urandom), 1'b0, none);
                else
                    send(1'($urandom_range(1)), 20'($urandom_range(300000, 700000)), 1'b0,
                         none);
            end
            drain();
        end
        calm = 1'b0;

        if (mismatches == 0 && readings_due.size() == 0)
            $display("barometric_sensor_compensation regression: pass");
        else
            $display("barometric_sensor_compensation regression: fail");
        $finish;
    end
endmodule
